FILE: rtl/core/rif_pkg.sv
// ============================================================================
// rif_pkg
// Shared constants for the radix integer formatter: character codes,
// configuration register indexes and alphabet layout.
// ============================================================================
`default_nettype none

package rif_pkg;

    // Configuration port layout
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 6;

    // Alphabet storage: four words of eight byte-wide symbols
    localparam int ALPHA_WORDS = 4;
    localparam int ALPHA_SLOTS = 32;
    localparam int SLOT_W      = 5;
    localparam int CHAR_W      = 7;

    // Register indexes (byte address / 8)
    localparam logic [2:0] REG_SYMBOL_COUNT = 3'd0;
    localparam logic [2:0] REG_ALPHA_WORD_0 = 3'd1;
    localparam logic [2:0] REG_ALPHA_WORD_1 = 3'd2;
    localparam logic [2:0] REG_ALPHA_WORD_2 = 3'd3;
    localparam logic [2:0] REG_ALPHA_WORD_3 = 3'd4;

    // Character codes
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;

endpackage

`default_nettype wire

FILE: rtl/core/rif_ram.sv
// ============================================================================
// rif_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module rif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/rif_divider.sv
// ============================================================================
// rif_divider
// Iterative restoring divider: unsigned dividend by a narrow divisor,
// four quotient bits per cycle, quotient and remainder held after done.
// ============================================================================
`default_nettype none

module rif_divider #(
    parameter int VALUE_WIDTH = 32,
    parameter int DIVISOR_W   = 6
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic      [VALUE_WIDTH-1:0] o_quotient,
    output logic      [DIVISOR_W-1:0]   o_remainder
);

    localparam int STEP   = 4;
    localparam int DIV_W  = ((VALUE_WIDTH + STEP - 1) / STEP) * STEP;
    localparam int PASSES = DIV_W / STEP;
    localparam int PASS_W = $clog2(PASSES + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [PASS_W-1:0]    r_pass, n_pass;
    logic [DIV_W-1:0]     r_quo,  n_quo;
    logic [DIVISOR_W-1:0] r_rem,  n_rem;
    logic [DIVISOR_W-1:0] r_div,  n_div;

    // Four restoring steps per cycle on the narrow remainder
    always_comb begin
        logic [DIVISOR_W:0]   v_part;
        logic [DIV_W-1:0]     v_quo;
        logic [DIVISOR_W-1:0] v_rem;
        v_quo  = r_quo;
        v_rem  = r_rem;
        v_part = '0;
        for (int s = 0; s < STEP; s++) begin
            v_part = {v_rem, v_quo[DIV_W-1]};
            v_quo  = {v_quo[DIV_W-2:0], 1'b0};
            if (v_part >= {1'b0, r_div}) begin
                v_part   = v_part - {1'b0, r_div};
                v_quo[0] = 1'b1;
            end
            v_rem = v_part[DIVISOR_W-1:0];
        end

        n_busy = r_busy;
        n_done = 1'b0;
        n_pass = r_pass;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_pass = PASS_W'(PASSES);
            n_quo  = DIV_W'(i_dividend);
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo  = v_quo;
            n_rem  = v_rem;
            n_pass = r_pass - 1'b1;
            if (r_pass == PASS_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state under reset, datapath free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_pass <= n_pass;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

FILE: rtl/core/radix_integer_formatter.sv
// ============================================================================
// radix_integer_formatter
// Writes a signed integer as text in a configured radix, one character per
// output item, most significant digit first, with a leading minus sign when negative.
// ============================================================================
// APB port (64-bit data, register i at byte 8*i): symbol_count, then
// alphabet words 0..3 (symbol 0 in the low byte). Write it only when idle.
// Input (i_in_valid / o_in_ready): one value per item. Output (o_out_valid /
// i_out_ready): one character per item, o_last on the final character.
// A taken value goes through an alphabet check, one symbol at a time, then
// one division per digit in the shared four-bit-per-cycle divider, then a
// minus sign when negative and the digits read back through the stack RAM
// port. A new value is taken only after the last character of the previous
// one is loaded. An invalid alphabet drops the value with no output.
// o_in_ready rises once the last character sits in the output register; a
// stalled receiver holds that register and pauses the sequencer.
// Synchronous reset clears the configuration and empties the output.
// ============================================================================
`default_nettype none

module radix_integer_formatter
    import rif_pkg::*;
#(
    parameter int MAX_SYMBOLS       = 32,
    parameter int VALUE_WIDTH       = 32,
    parameter int DIGIT_STACK_DEPTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [CFG_ADDR_W-1:0]         paddr,
    input  wire logic [CFG_DATA_W-1:0]         pwdata,
    output logic      [CFG_DATA_W-1:0]         prdata,
    output logic                               pready,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [CHAR_W-1:0]             o_character,
    output logic                               o_last
);

    localparam int RADIX_W = $clog2(MAX_SYMBOLS + 1);
    localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
    localparam int AW      = $clog2(DIGIT_STACK_DEPTH);
    localparam int CW      = $clog2(DIGIT_STACK_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_SIGN  = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_LOAD  = 7'b1000000
    } t_state;

    // Configuration registers
    logic [COUNT_W-1:0]    r_count;
    logic [CFG_DATA_W-1:0] r_alpha [ALPHA_WORDS];
    logic [7:0]            w_sym   [ALPHA_SLOTS];

    // Sequencer and datapath registers
    t_state               r_state, n_state;
    logic                 r_neg,   n_neg;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic [SLOT_W-1:0]    r_idx,   n_idx;
    logic [CW-1:0]        r_cnt,   n_cnt;
    logic [AW-1:0]        r_ptr,   n_ptr;
    logic                 r_ov,    n_ov;
    logic [CHAR_W-1:0]    r_oc,    n_oc;
    logic                 r_ol,    n_ol;

    logic                   w_cfg_wr;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [VALUE_WIDTH-1:0] w_raw;
    logic                   w_count_ok;
    logic [7:0]             w_c;
    logic                   w_dup;
    logic                   w_bad;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [VALUE_WIDTH-1:0] w_quo;
    logic [RADIX_W-1:0]     w_rem;
    logic                   w_push;
    logic                   w_finish;
    logic [DIGIT_W-1:0]     w_rd_digit;
    logic [7:0]             w_digit_sym;

    // Unpack the alphabet into byte-wide symbols
    always_comb begin
        for (int k = 0; k < ALPHA_SLOTS; k++) begin
            w_sym[k] = r_alpha[k / 8][(k % 8) * 8 +: 8];
        end
    end

    // Configuration writes
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int w = 0; w < ALPHA_WORDS; w++) begin
                r_alpha[w] <= '0;
            end
        end else if (w_cfg_wr) begin
            case (paddr[5:3])
                REG_SYMBOL_COUNT: r_count    <= pwdata[COUNT_W-1:0];
                REG_ALPHA_WORD_0: r_alpha[0] <= pwdata;
                REG_ALPHA_WORD_1: r_alpha[1] <= pwdata;
                REG_ALPHA_WORD_2: r_alpha[2] <= pwdata;
                REG_ALPHA_WORD_3: r_alpha[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[5:3])
            REG_SYMBOL_COUNT: prdata = CFG_DATA_W'(r_count);
            REG_ALPHA_WORD_0: prdata = r_alpha[0];
            REG_ALPHA_WORD_1: prdata = r_alpha[1];
            REG_ALPHA_WORD_2: prdata = r_alpha[2];
            REG_ALPHA_WORD_3: prdata = r_alpha[3];
            default:          prdata = '0;
        endcase
    end

    // Alphabet check: one symbol per cycle against every later symbol
    assign w_count_ok = (r_count >= COUNT_W'(2)) && (r_count <= COUNT_W'(MAX_SYMBOLS));
    assign w_c        = w_sym[r_idx];

    always_comb begin
        w_dup = 1'b0;
        for (int j = 0; j < ALPHA_SLOTS; j++) begin
            if ((COUNT_W'(j) > COUNT_W'(r_idx)) && (COUNT_W'(j) < r_count) &&
                (w_sym[j] == w_c)) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_bad = (w_c == CHAR_PLUS) || (w_c == CHAR_MINUS) ||
                   (w_c < PRINT_LOW) || (w_c > PRINT_HIGH) || w_dup;

    // Shared divider
    assign w_div_start = (r_state == S_DIV);

    rif_divider #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIVISOR_W   (RADIX_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_mag),
        .i_divisor   (r_count[RADIX_W-1:0]),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Digit stack, least significant digit at address 0
    assign w_push   = (r_state == S_WAIT) && w_div_done;
    assign w_finish = (w_quo == '0) || (r_cnt == CW'(DIGIT_STACK_DEPTH - 1));

    rif_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_rem[DIGIT_W-1:0]),
        .i_raddr (r_ptr),
        .o_rdata (w_rd_digit)
    );

    assign w_digit_sym = w_sym[SLOT_W'(w_rd_digit)];

    // Handshakes
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_out_free = !r_ov || i_out_ready;
    assign w_raw      = unsigned'(i_value);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_ov    = r_ov && !i_out_ready;
        n_oc    = r_oc;
        n_ol    = r_ol;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_neg = w_raw[VALUE_WIDTH-1];
                    n_mag = w_raw[VALUE_WIDTH-1] ? (~w_raw + 1'b1) : w_raw;
                    n_idx = '0;
                    n_cnt = '0;
                    if (w_count_ok) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_bad) begin
                    n_state = S_IDLE;
                end else if (COUNT_W'(r_idx) == r_count - 1'b1) begin
                    n_state = S_DIV;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIV: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_div_done) begin
                    n_mag = w_quo;
                    n_cnt = r_cnt + 1'b1;
                    if (w_finish) begin
                        n_ptr   = r_cnt[AW-1:0];
                        n_state = r_neg ? S_SIGN : S_FETCH;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_oc    = CHAR_MINUS[CHAR_W-1:0];
                    n_ol    = 1'b0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_oc = w_digit_sym[CHAR_W-1:0];
                    n_ol = (r_ptr == '0);
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; payload registers need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_ptr <= n_ptr;
        r_oc  <= n_oc;
        r_ol  <= n_ol;
    end

    assign o_out_valid = r_ov;
    assign o_character = r_oc;
    assign o_last      = r_ol;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - radix integer formatter testbench
// Programs alphabets over APB, sends signed values, and checks every output
// character and its last flag against a local model of the formatter.
// Covers valid and invalid alphabets and random source and sink idling.
// ============================================================================

module tb;
    import rif_pkg::*;

    // Timing and run length
    localparam int SETTLE_CYCLES = 600;
    localparam int QUIET_LIMIT   = 20000;
    localparam int RANDOM_VALUES = 150;
    localparam int REPORT_MAX    = 10;

    // Register indexes that map to nothing
    localparam logic [2:0] REG_SPARE_5 = 3'd5;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef enum int {
        BAD_COUNT, BAD_PLUS, BAD_MINUS, BAD_LOW, BAD_HIGH, BAD_REPEAT
    } t_alpha_fault;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Block ports
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr   = '0;
    logic [CFG_DATA_W-1:0]  pwdata  = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic signed [31:0]     i_value     = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [CHAR_W-1:0]      o_character;
    logic                   o_last;

    radix_integer_formatter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // Shadow registers and text prediction
    logic [COUNT_W-1:0]    cfg_symbol_count = '0;
    logic [63:0]           cfg_alphabet [ALPHA_WORDS] = '{default: '0};
    logic [7:0]            staged_symbols [ALPHA_SLOTS];
    t_text_char            expected_text [$];
    logic signed [31:0]    pending_values [$];

    int  sent_count     = 0;
    int  accepted_count = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  phase_index    = 0;
    logic value_taken   = 1'b0;

    function automatic logic [7:0] symbol_of(input int k);
        return cfg_alphabet[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    function automatic bit alphabet_valid();
        int         n;
        logic [7:0] c;
        n = int'(cfg_symbol_count);
        if (n < 2 || n > ALPHA_SLOTS) return 1'b0;
        for (int i = 0; i < n; i++) begin
            c = symbol_of(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
            if (c < PRINT_LOW || c > PRINT_HIGH) return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (symbol_of(j) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Append the characters that one value turns into
    function automatic void format_value(input logic signed [31:0] value);
        logic [31:0] magnitude;
        logic [31:0] radix;
        logic [7:0]  sym;
        int          digits [$];
        t_text_char  ch;
        if (!alphabet_valid()) return;
        radix     = 32'(cfg_symbol_count);
        magnitude = value[31] ? (~value + 32'd1) : value;
        do begin
            digits.push_front(int'(magnitude % radix));
            magnitude = magnitude / radix;
        end while (magnitude != 0);
        if (value[31]) begin
            ch.code = CHAR_MINUS[CHAR_W-1:0];
            ch.last = 1'b0;
            expected_text.push_back(ch);
        end
        foreach (digits[i]) begin
            sym     = symbol_of(digits[i]);
            ch.code = sym[CHAR_W-1:0];
            ch.last = (i == digits.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // Input driver: present values, hold until taken; sink ready at random
    always @(negedge i_clk) begin
        if (!i_in_valid || value_taken) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_value    <= pending_values.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on each taken value, check each taken character
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            value_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                format_value(i_value);
                accepted_count++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_text.size() == 0) begin
                    note_mismatch($sformatf("unexpected item: char %0d last %0d",
                                            o_character, o_last));
                end else begin
                    want = expected_text.pop_front();
                    if (o_character !== want.code || o_last !== want.last)
                        note_mismatch($sformatf(
                            "mismatch: expected char %0d last %0d, got char %0d last %0d",
                            want.code, want.last, o_character, o_last));
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SYMBOL_COUNT)
            cfg_symbol_count = data[COUNT_W-1:0];
        else if (idx >= REG_ALPHA_WORD_0 && idx <= REG_ALPHA_WORD_3)
            cfg_alphabet[2'(idx - REG_ALPHA_WORD_0)] = data;
    endtask

    // Write the count (junk above its field) and the staged alphabet words
    task automatic program_staged(input int count);
        logic [63:0] word;
        word = {$urandom, $urandom};
        word[COUNT_W-1:0] = count[COUNT_W-1:0];
        write_reg(REG_SYMBOL_COUNT, word);
        for (int w = 0; w < ALPHA_WORDS; w++) begin
            for (int b = 0; b < 8; b++) word[b * 8 +: 8] = staged_symbols[w * 8 + b];
            write_reg(REG_ALPHA_WORD_0 + w[2:0], word);
        end
    endtask

    task automatic program_text(input int count, input string text);
        for (int k = 0; k < ALPHA_SLOTS; k++)
            staged_symbols[k] = (k < text.len()) ? text[k] : 8'hFF;
        program_staged(count);
    endtask

    // Stage distinct printable symbols, junk past the count
    task automatic stage_random_alphabet(input int count);
        logic [7:0] pool [$];
        int         pick;
        for (int c = PRINT_LOW; c <= PRINT_HIGH; c++)
            if (c != CHAR_PLUS && c != CHAR_MINUS) pool.push_back(c[7:0]);
        for (int k = 0; k < ALPHA_SLOTS; k++) begin
            pick = $urandom_range(pool.size() - 1);
            staged_symbols[k] = pool[pick];
            pool.delete(pick);
            if (k >= count) staged_symbols[k] = 8'($urandom_range(255));
        end
    endtask

    // Break one rule of a staged alphabet of at least two symbols
    task automatic inject_fault(input t_alpha_fault fault, input int count);
        int i;
        int j;
        i = $urandom_range(count - 1);
        j = (i + 1 + $urandom_range(count - 2)) % count;
        case (fault)
            BAD_PLUS:   staged_symbols[i] = CHAR_PLUS;
            BAD_MINUS:  staged_symbols[i] = CHAR_MINUS;
            BAD_LOW:    staged_symbols[i] = 8'($urandom_range(PRINT_LOW - 1));
            BAD_HIGH:   staged_symbols[i] = 8'($urandom_range(255, PRINT_HIGH + 1));
            BAD_REPEAT: staged_symbols[j] = staged_symbols[i];
            default: begin
            end
        endcase
    endtask

    function automatic logic signed [31:0] random_value();
        logic signed [31:0] v;
        longint             p;
        int                 radix;
        radix = (cfg_symbol_count >= 2) ? int'(cfg_symbol_count) : 10;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $signed($urandom_range(600)) - 300;
            2: v = $urandom_range(1) ? (32'sh8000_0000 + $urandom_range(3))
                                     : (32'sh7FFF_FFFF - $urandom_range(3));
            3: v = $urandom >> $urandom_range(31);
            default: begin
                p = 1;
                repeat ($urandom_range(31))
                    if (p * radix <= 64'sd2147483647) p = p * radix;
                v = 32'(p - $urandom_range(1));
            end
        endcase
        if ($urandom_range(3) == 0) v = -v;
        return v;
    endfunction

    // Send a batch of values under the next idling mode, then drain
    task automatic run_values(input logic signed [31:0] batch [$]);
        case (phase_index % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
        phase_index++;
        sent_count += batch.size();
        foreach (batch[i]) pending_values.push_back(batch[i]);
        while (accepted_count != sent_count || expected_text.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic signed [31:0] batch [$];
        t_alpha_fault       fault;
        int                 count;
        int                 valid_sent;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset alphabet is empty: values are dropped
        run_values('{0, -1});

        // Decimal; junk in unused words and writes to unmapped indexes
        program_text(10, "0123456789");
        write_reg(REG_ALPHA_WORD_3, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_SPARE_5, {$urandom, $urandom});
        write_reg(REG_SPARE_7, {$urandom, $urandom});
        run_values('{0, 9, -10, 32'sh7FFF_FFFF, 32'sh8000_0000});

        // Smallest radix
        program_text(2, "01");
        run_values('{32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0});

        // Largest radix with space and tilde as symbols
        program_text(32, "~ abcdefghijklmnopqrstuvwxyz0123");
        run_values('{0, 32, 32'sh8000_0000, 32'sh7FFF_FFFF, -1});

        // Invalid counts: zero, one, above the limit, all ones
        write_reg(REG_ALPHA_WORD_0, 64'h0);
        write_reg(REG_SYMBOL_COUNT, 64'h0);
        run_values('{12345});
        program_text(1, "01");
        run_values('{-12345});
        program_text(33, "~ abcdefghijklmnopqrstuvwxyz0123");
        run_values('{77});
        program_text(63, "~ abcdefghijklmnopqrstuvwxyz0123");
        run_values('{-77});

        // Invalid symbols: plus, minus, control, above printable, repeated
        for (int f = BAD_PLUS; f <= BAD_REPEAT; f++) begin
            stage_random_alphabet(10);
            inject_fault(t_alpha_fault'(f), 10);
            program_staged(10);
            run_values('{$urandom});
        end

        // Random alphabets and values, with a few broken alphabets mixed in
        valid_sent = 0;
        while (valid_sent < RANDOM_VALUES) begin
            batch = {};
            if ($urandom_range(4) == 0) begin
                fault = t_alpha_fault'($urandom_range(BAD_REPEAT));
                count = $urandom_range(2, ALPHA_SLOTS);
                if (fault == BAD_COUNT)
                    count = $urandom_range(2) == 0 ? $urandom_range(1)
                                                   : $urandom_range(33, 63);
                stage_random_alphabet(count);
                if (fault != BAD_COUNT) inject_fault(fault, count);
                program_staged(count);
                repeat (3) batch.push_back(random_value());
            end else begin
                case ($urandom_range(4))
                    0:       count = 2;
                    1:       count = ALPHA_SLOTS;
                    default: count = $urandom_range(2, ALPHA_SLOTS);
                endcase
                stage_random_alphabet(count);
                program_staged(count);
                repeat (15) batch.push_back(random_value());
                valid_sent += 15;
            end
            run_values(batch);
        end

        if (expected_text.size() != 0)
            note_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
